// ===== rtl/pooling_gradient_scatter_assert.svh =====
// assertion macros for the pooling gradient scatter rtl
`ifndef POOLING_GRADIENT_SCATTER_ASSERT_SVH
`define POOLING_GRADIENT_SCATTER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PGS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PGS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pgs_pkg.sv =====
// package: types and constants of the pooling gradient scatter
package pgs_pkg;

    localparam int unsigned GRAD_W   = 32;
    localparam int unsigned ENTRY_W  = 12;
    localparam int unsigned POS_W    = 6;
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned CFG_DAT_W = 8;
    localparam int unsigned ADD_W    = 34;
    localparam int unsigned RECIP_NUM_W = 17;
    localparam logic [RECIP_NUM_W-1:0] ONE_Q16 = 17'h10000;
    localparam logic [15:0] HALF_Q16 = 16'h8000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_TYPE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_W  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_H  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_W  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_H  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD       = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT = 4'd7;

    // item and pooling codes
    localparam logic MODE_ACC  = 1'b0;
    localparam logic MODE_READ = 1'b1;
    localparam logic POOL_MAX  = 1'b0;
    localparam logic POOL_AVG  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BOUNDS,
        ST_AREA,
        ST_DIV,
        ST_MUL,
        ST_ROUND,
        ST_SCAN
    } pgs_state_t;

    // write-back stage of a read-modify-write
    typedef struct packed {
        logic               valid;
        logic               clear;
        logic [ENTRY_W-1:0] entry;
    } pgs_wb_t;

endpackage

// ===== rtl/pgs_div.sv =====
// restoring divider, one quotient bit per cycle, for the window reciprocal
module pgs_div
    import pgs_pkg::*;
#(
    parameter int unsigned DEN_W = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [RECIP_NUM_W-1:0] num,
    input  logic [DEN_W-1:0]       den,
    output logic                   done,
    output logic [RECIP_NUM_W-1:0] quot
);

    localparam int unsigned CNT_W = $clog2(RECIP_NUM_W + 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [DEN_W:0]         rem_reg, rem_next;
    logic [RECIP_NUM_W-1:0] num_reg, num_next;
    logic [RECIP_NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W-1:0]       den_reg, den_next;
    logic [DEN_W+1:0]       trial;

    // load on start, else one shift-and-subtract step while busy
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        trial     = {rem_reg, num_reg[RECIP_NUM_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(RECIP_NUM_W);
            rem_next  = '0;
            num_next  = num;
            quot_next = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[RECIP_NUM_W-2:0], 1'b0};
            if (trial >= {2'b00, den_reg})
            begin
                rem_next  = (DEN_W+1)'(trial - {2'b00, den_reg});
                quot_next = {quot_reg[RECIP_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[DEN_W:0];
                quot_next = {quot_reg[RECIP_NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== rtl/pooling_gradient_scatter.sv =====
// top level: pooling gradient scatter with its accumulation memory
// After reset the block clears its PLANE_DEPTH-entry plane memory, one entry a
// cycle, and accepts no item until that clearing pass ends. Every entry update is
// a read-modify-write on the single plane memory, so that memory port sets the
// pace: an item is not taken until the write-back of the previous one is done;
// an average-mode accumulate first sets up the window (bounds, area, a reciprocal
// divide, multiply and round) and then updates one window cell per cycle, for a
// window of up to 8 by 8 cells.
module pooling_gradient_scatter
    import pgs_pkg::*;
#(
    parameter int unsigned PLANE_DEPTH = 4096,
    parameter int unsigned WINDOW_MAX  = 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DAT_W-1:0]       cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       mode,
    input  logic signed [GRAD_W-1:0]   grad,
    input  logic [ENTRY_W-1:0]         argmax_addr,
    input  logic [POS_W-1:0]           out_row,
    input  logic [POS_W-1:0]           out_col,
    input  logic [ENTRY_W-1:0]         read_addr,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [GRAD_W-1:0]   grad_sum,
    output logic [ENTRY_W-1:0]         entry_addr
);

`include "pooling_gradient_scatter_assert.svh"

    localparam int unsigned ADDR_W = $clog2(PLANE_DEPTH);
    localparam int unsigned WIN_W  = $clog2(WINDOW_MAX + 1);
    localparam int unsigned AREA_W = 2 * WIN_W;

    // configuration registers
    logic       pool_type_reg;
    logic [3:0] filter_w_reg, filter_h_reg, stride_w_reg, stride_h_reg;
    logic [2:0] pad_reg;
    logic [6:0] in_width_reg, in_height_reg;

    pgs_state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg;
    pgs_wb_t           wb_reg, wb_next;
    logic [ADDR_W-1:0] wb_addr_reg, wb_addr_next;

    logic signed [GRAD_W-1:0] grad_reg;
    logic [POS_W-1:0]  row_reg, col_reg;
    logic [9:0]        hs_reg, ws_reg;
    logic [6:0]        he_reg, we_reg;
    logic signed [49:0]      prod_reg;
    logic signed [ADD_W-1:0] addend_reg;
    logic [6:0]        h_reg, w_reg;

    logic                 out_valid_reg;
    logic [GRAD_W-1:0]    grad_sum_reg;
    logic [ENTRY_W-1:0]   entry_addr_reg;

    logic [GRAD_W-1:0] mem [PLANE_DEPTH];
    logic [GRAD_W-1:0] rd_data_reg;
    logic              mem_re, mem_we;
    logic [ADDR_W-1:0] mem_raddr, mem_waddr;
    logic [GRAD_W-1:0] mem_wdata;

    logic in_acc;
    logic read_in_range, max_in_range, cell_in_range;
    logic [14:0] cell_addr;
    logic        last_col, last_row, win_empty;

    logic [WIN_W-1:0] fw_clamp, fh_clamp;
    logic [9:0]  r_prod, c_prod;
    logic [10:0] r_start, c_start, r_end, c_end;
    logic [9:0]  r_hs, c_hs;
    logic [6:0]  r_he, c_he;
    logic [9:0]  dh_full, dw_full;
    logic [AREA_W-1:0] area_calc;

    logic                   div_start, div_done;
    logic [RECIP_NUM_W-1:0] div_num, div_quot;

    logic signed [34:0] sum_ext;
    logic [GRAD_W-1:0]  sum_sat;

    // configuration write, always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_type_reg <= POOL_MAX;
            filter_w_reg  <= 4'd1;
            filter_h_reg  <= 4'd1;
            stride_w_reg  <= 4'd1;
            stride_h_reg  <= 4'd1;
            pad_reg       <= 3'd0;
            in_width_reg  <= 7'd64;
            in_height_reg <= 7'd64;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_POOL_TYPE: pool_type_reg <= cfg_data[0];
                CFG_FILTER_W:  filter_w_reg  <= cfg_data[3:0];
                CFG_FILTER_H:  filter_h_reg  <= cfg_data[3:0];
                CFG_STRIDE_W:  stride_w_reg  <= cfg_data[3:0];
                CFG_STRIDE_H:  stride_h_reg  <= cfg_data[3:0];
                CFG_PAD:       pad_reg       <= cfg_data[2:0];
                CFG_IN_WIDTH:  in_width_reg  <= cfg_data[6:0];
                CFG_IN_HEIGHT: in_height_reg <= cfg_data[6:0];
                default:       ;
            endcase
        end
    end

    // range checks against the plane depth, scan address and window end flags
    assign read_in_range = 32'(read_addr) < PLANE_DEPTH;
    assign max_in_range  = 32'(argmax_addr) < PLANE_DEPTH;
    assign cell_addr     = 15'(14'(h_reg) * 14'(in_width_reg)) + 15'(w_reg);
    assign cell_in_range = 32'(cell_addr) < PLANE_DEPTH;
    assign last_col      = (w_reg + 7'd1) == we_reg;
    assign last_row      = (h_reg + 7'd1) == he_reg;
    assign win_empty     = (10'(he_reg) <= hs_reg) || (10'(we_reg) <= ws_reg);

    // clipped window bounds and window area
    always_comb
    begin
        if (filter_w_reg == 4'd0)
            fw_clamp = WIN_W'(1);
        else if (32'(filter_w_reg) > WINDOW_MAX)
            fw_clamp = WIN_W'(WINDOW_MAX);
        else
            fw_clamp = WIN_W'(filter_w_reg);
        if (filter_h_reg == 4'd0)
            fh_clamp = WIN_W'(1);
        else if (32'(filter_h_reg) > WINDOW_MAX)
            fh_clamp = WIN_W'(WINDOW_MAX);
        else
            fh_clamp = WIN_W'(filter_h_reg);
        r_prod  = 10'(row_reg) * 10'(stride_h_reg);
        c_prod  = 10'(col_reg) * 10'(stride_w_reg);
        r_start = 11'(r_prod) - 11'(pad_reg);
        c_start = 11'(c_prod) - 11'(pad_reg);
        r_hs    = r_start[10] ? 10'd0 : r_start[9:0];
        c_hs    = c_start[10] ? 10'd0 : c_start[9:0];
        r_end   = 11'(r_hs) + 11'(fh_clamp);
        c_end   = 11'(c_hs) + 11'(fw_clamp);
        r_he    = (r_end > 11'(in_height_reg)) ? in_height_reg : r_end[6:0];
        c_he    = (c_end > 11'(in_width_reg)) ? in_width_reg : c_end[6:0];
        dh_full   = 10'(he_reg) - hs_reg;
        dw_full   = 10'(we_reg) - ws_reg;
        area_calc = AREA_W'(dh_full[WIN_W-1:0]) * AREA_W'(dw_full[WIN_W-1:0]);
    end

    // reciprocal of the window area, rounded, started from the area state
    assign div_num = ONE_Q16 + RECIP_NUM_W'(area_calc >> 1);

    pgs_div #(
        .DEN_W (AREA_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (area_calc),
        .done  (div_done),
        .quot  (div_quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (clr_cnt_reg == ADDR_W'(PLANE_DEPTH - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (in_acc && mode == MODE_ACC && pool_type_reg == POOL_AVG)
                    state_next = ST_BOUNDS;
            ST_BOUNDS:
                state_next = ST_AREA;
            ST_AREA:
                state_next = win_empty ? ST_IDLE : ST_DIV;
            ST_DIV:
                if (div_done)
                    state_next = ST_MUL;
            ST_MUL:
                state_next = ST_ROUND;
            ST_ROUND:
                state_next = ST_SCAN;
            ST_SCAN:
                if (last_col && last_row)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = !wb_reg.valid &&
                    (mode == MODE_ACC || !out_valid_reg || out_ready);
                if (in_valid && in_ready)
                begin
                    if (mode == MODE_READ)
                    begin
                        mem_re    = read_in_range;
                        mem_raddr = ADDR_W'(32'(read_addr));
                    end
                    else if (pool_type_reg == POOL_MAX)
                    begin
                        mem_re    = max_in_range;
                        mem_raddr = ADDR_W'(32'(argmax_addr));
                    end
                end
            end
            ST_AREA:
                div_start = !win_empty;
            ST_SCAN:
            begin
                mem_re    = cell_in_range;
                mem_raddr = ADDR_W'(32'(cell_addr));
            end
            default:
                ;
        endcase
    end

    assign in_acc = in_valid && in_ready;

    // write-back stage follows every issued read
    always_comb
    begin
        wb_next.valid = mem_re;
        wb_next.clear = (state_reg == ST_IDLE) && (mode == MODE_READ);
        wb_next.entry = read_addr;
        wb_addr_next  = mem_raddr;
    end

    // saturating add of the stored entry and the addend, and the memory write select
    always_comb
    begin
        sum_ext = 35'($signed(rd_data_reg)) + 35'(addend_reg);
        if (sum_ext[34:31] == 4'b0000 || sum_ext[34:31] == 4'b1111)
            sum_sat = sum_ext[31:0];
        else if (sum_ext[34])
            sum_sat = {1'b1, {(GRAD_W-1){1'b0}}};
        else
            sum_sat = {1'b0, {(GRAD_W-1){1'b1}}};
        mem_we    = (state_reg == ST_CLEAR) || wb_reg.valid;
        mem_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : wb_addr_reg;
        mem_wdata = ((state_reg == ST_CLEAR) || wb_reg.clear) ? '0 : sum_sat;
    end

    // plane memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            wb_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wb_reg    <= wb_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (wb_reg.valid && wb_reg.clear)
                out_valid_reg <= 1'b1;
            else if (in_acc && mode == MODE_READ && !read_in_range)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        wb_addr_reg <= wb_addr_next;
        if (wb_reg.valid && wb_reg.clear)
        begin
            grad_sum_reg   <= rd_data_reg;
            entry_addr_reg <= wb_reg.entry;
        end
        else if (in_acc && mode == MODE_READ && !read_in_range)
        begin
            grad_sum_reg   <= '0;
            entry_addr_reg <= read_addr;
        end
        if (in_acc)
        begin
            grad_reg   <= grad;
            row_reg    <= out_row;
            col_reg    <= out_col;
            addend_reg <= ADD_W'(grad);
        end
        case (state_reg)
            ST_BOUNDS:
            begin
                hs_reg <= r_hs;
                he_reg <= r_he;
                ws_reg <= c_hs;
                we_reg <= c_he;
            end
            ST_MUL:
                prod_reg <= grad_reg * $signed({1'b0, div_quot});
            ST_ROUND:
            begin
                addend_reg <= ADD_W'((prod_reg + 50'(HALF_Q16)) >>> 16);
                h_reg      <= hs_reg[6:0];
                w_reg      <= ws_reg[6:0];
            end
            ST_SCAN:
            begin
                if (last_col)
                begin
                    w_reg <= ws_reg[6:0];
                    h_reg <= h_reg + 7'd1;
                end
                else
                begin
                    w_reg <= w_reg + 7'd1;
                end
            end
            default:
                ;
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign grad_sum   = grad_sum_reg;
    assign entry_addr = entry_addr_reg;

    // checks on the controller
    `PGS_ASSERT_NOW(a_no_accept_clearing, state_reg == ST_CLEAR, !in_ready,
        "item accepted during the clearing pass")
    `PGS_ASSERT_NOW(a_wb_interlock, wb_reg.valid, !in_ready,
        "item accepted while a write-back is pending")
    `PGS_ASSERT_NEXT(a_read_gives_result, in_acc && mode == MODE_READ,
        (wb_reg.valid && wb_reg.clear) || out_valid_reg,
        "read transaction produced no result")
    `PGS_ASSERT_NOW(a_div_done_in_div, div_done, state_reg == ST_DIV,
        "divider finished outside the divide state")

endmodule
